// ----- rtl/core/xcfp_pkg.sv -----
// Shared types and constants for the XOR-checked frame parser.
package xcfp_pkg;

  // Default frame size limit in bytes, overhead included.
  localparam int MAX_FRAME_BYTES_DEF = 64;
  // Bytes of a frame that are not payload: start, sequence, length, id, checksum, end.
  localparam int OVERHEAD_BYTES      = 6;
  // Header bytes ahead of the payload.
  localparam int HDR_BYTES           = 4;
  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF     = 4;

  // Frame byte positions with a fixed meaning in the header.
  localparam logic [8:0] POS_LENGTH = 9'd2;
  localparam logic [8:0] POS_ID     = 9'd3;

  typedef enum logic {
    REC_WORD   = 1'b0,
    REC_STATUS = 1'b1
  } rec_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_END  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_BAD_CSUM = 2'd3
  } status_t;

  // Command handed from front to back through the queue.
  typedef struct packed {
    rec_kind_t   kind;
    logic [15:0] word;      // payload word, word commands only
    logic [7:0]  frame_id;
    logic [7:0]  end_byte;  // byte at the end-marker position, status commands only
    logic        too_long;
    logic        csum_ok;
  } cmd_t;

endpackage

// ----- rtl/core/xor_checked_frame_parser_top.sv -----
// Top level of the XOR-checked byte frame parser.
//
// Takes one frame byte per cycle on the s_ side (s_tuser high marks byte 0 of a
// frame) while the command queue has room. Layout: start, sequence, length L,
// destination id, L payload bytes, XOR checksum of all earlier bytes, end
// marker. Each completed payload pair leaves at once as a big-endian word
// record (m_tuser 0); treat it as provisional. The end-marker byte yields a
// status record (m_tuser 1, m_tlast 1): ok, bad end byte, too long or bad
// checksum, checked in that order; keep or drop the frame's words on it. A
// record reaches m_ through the command queue, written at the accepting edge,
// and then the output register. The front parser and the output stage are
// parted by a QUEUE_DEPTH entry command queue, so s_tready only drops when
// that queue fills under sustained m_tready backpressure. Bytes outside a
// frame are dropped; a new start inside a frame abandons it without status.
// Write end_marker on cfg_ only while the block is idle; cfg_ready is always
// high.
module xor_checked_frame_parser_top #(
  parameter int MAX_FRAME_BYTES = xcfp_pkg::MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = xcfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: end marker byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] frame_start
  // Record stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] data_word, [23:16] frame_id, [25:24] status, rest 0
  output logic        m_tuser,   // [0] record_type
  output logic        m_tlast    // last
);

  xcfp_pkg::cmd_t push_cmd, head;
  logic           push, full, pop, avail;
  logic [15:0]    data_word;
  logic [7:0]     frame_id;
  logic [1:0]     status;

  assign cfg_ready = 1'b1;

  // Parse and classify each byte.
  xcfp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .data_byte  (s_tdata),
    .frame_start(s_tuser),
    .queue_full (full),
    .byte_ready (s_tready),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Buffer commands so each side can stall on its own.
  xcfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (full),
    .pop     (pop),
    .avail   (avail),
    .head    (head)
  );

  // Resolve status and drive the output register.
  xcfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .avail      (avail),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .record_type(m_tuser),
    .data_word  (data_word),
    .frame_id   (frame_id),
    .status     (status),
    .last       (m_tlast)
  );

  assign m_tdata = {6'd0, status, frame_id, data_word};

endmodule

// ----- rtl/core/xcfp_front.sv -----
// Front end: tracks frame position and checksum, emits word and status commands.
module xcfp_front #(
  parameter int MAX_FRAME_BYTES = xcfp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  input  logic [7:0]     data_byte,
  input  logic           frame_start,
  input  logic           queue_full,
  output logic           byte_ready,
  output logic           push,
  output xcfp_pkg::cmd_t cmd
);

  localparam logic [8:0] MAX_PAYLOAD =
    9'(MAX_FRAME_BYTES - xcfp_pkg::OVERHEAD_BYTES);
  localparam logic [8:0] HDR = 9'(xcfp_pkg::HDR_BYTES);

  logic       in_frame, in_frame_next;
  logic [8:0] byte_position, byte_position_next;
  logic [7:0] payload_length, payload_length_next;
  logic [7:0] frame_id_reg, frame_id_reg_next;
  logic [7:0] xor_accumulator, xor_accumulator_next;
  logic [7:0] received_checksum, received_checksum_next;
  logic [7:0] high_byte_hold, high_byte_hold_next;

  logic       take;
  logic [8:0] chk_pos;

  assign byte_ready = !queue_full;
  assign take       = byte_valid && byte_ready;
  assign chk_pos    = {1'b0, payload_length} + HDR;

  always_comb begin
    in_frame_next          = in_frame;
    byte_position_next     = byte_position;
    payload_length_next    = payload_length;
    frame_id_reg_next      = frame_id_reg;
    xor_accumulator_next   = xor_accumulator;
    received_checksum_next = received_checksum;
    high_byte_hold_next    = high_byte_hold;
    push                   = 1'b0;
    cmd.kind               = xcfp_pkg::REC_WORD;
    cmd.word               = {high_byte_hold, data_byte};
    cmd.frame_id           = frame_id_reg;
    cmd.end_byte           = data_byte;
    cmd.too_long           = ({1'b0, payload_length} > MAX_PAYLOAD);
    cmd.csum_ok            = (xor_accumulator == received_checksum);
    if (take) begin
      if (frame_start) begin
        in_frame_next          = 1'b1;
        byte_position_next     = 9'd1;
        payload_length_next    = '0;
        frame_id_reg_next      = '0;
        received_checksum_next = '0;
        high_byte_hold_next    = '0;
        xor_accumulator_next   = data_byte;
      end else if (in_frame) begin
        if (byte_position < HDR) begin
          xor_accumulator_next = xor_accumulator ^ data_byte;
          if (byte_position == xcfp_pkg::POS_LENGTH) begin
            payload_length_next = data_byte;
          end else if (byte_position == xcfp_pkg::POS_ID) begin
            frame_id_reg_next = data_byte;
          end
          byte_position_next = byte_position + 9'd1;
        end else if (byte_position < chk_pos) begin
          xor_accumulator_next = xor_accumulator ^ data_byte;
          byte_position_next   = byte_position + 9'd1;
          // Header length is even, so position parity gives payload pair half.
          if (!byte_position[0]) begin
            high_byte_hold_next = data_byte;
          end else begin
            push = 1'b1;
          end
        end else if (byte_position == chk_pos) begin
          received_checksum_next = data_byte;
          byte_position_next     = byte_position + 9'd1;
        end else begin
          push               = 1'b1;
          cmd.kind           = xcfp_pkg::REC_STATUS;
          in_frame_next      = 1'b0;
          byte_position_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame          <= 1'b0;
      byte_position     <= '0;
      payload_length    <= '0;
      frame_id_reg      <= '0;
      xor_accumulator   <= '0;
      received_checksum <= '0;
      high_byte_hold    <= '0;
    end else begin
      in_frame          <= in_frame_next;
      byte_position     <= byte_position_next;
      payload_length    <= payload_length_next;
      frame_id_reg      <= frame_id_reg_next;
      xor_accumulator   <= xor_accumulator_next;
      received_checksum <= received_checksum_next;
      high_byte_hold    <= high_byte_hold_next;
    end
  end

  // A status command closes the frame.
  a_status_closes: assert property (@(posedge clk) disable iff (rst)
    (push && cmd.kind == xcfp_pkg::REC_STATUS) |=> !in_frame)
    else $error("frame still open after status");

endmodule

// ----- rtl/core/xcfp_queue.sv -----
// Short command queue between front and back.
module xcfp_queue #(
  parameter int DEPTH = xcfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  xcfp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output xcfp_pkg::cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  xcfp_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign avail   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("command pushed into a full queue");

endmodule

// ----- rtl/core/xcfp_back.sv -----
// Back end: resolves frame status and holds the output record.
module xcfp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [7:0]     cfg_data,
  input  logic           avail,
  input  xcfp_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           record_type,
  output logic [15:0]    data_word,
  output logic [7:0]     frame_id,
  output logic [1:0]     status,
  output logic           last
);

  logic [7:0]        end_marker_reg;
  xcfp_pkg::status_t stat;
  logic              is_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker_reg <= '0;
    end else if (cfg_valid) begin
      end_marker_reg <= cfg_data;
    end
  end

  assign is_status = (head.kind == xcfp_pkg::REC_STATUS);
  assign pop       = avail && (!out_valid || out_ready);

  // End byte first, then length, then checksum.
  always_comb begin
    priority if (head.end_byte != end_marker_reg) begin
      stat = xcfp_pkg::ST_BAD_END;
    end else if (head.too_long) begin
      stat = xcfp_pkg::ST_TOO_LONG;
    end else if (!head.csum_ok) begin
      stat = xcfp_pkg::ST_BAD_CSUM;
    end else begin
      stat = xcfp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      record_type <= head.kind;
      data_word   <= is_status ? 16'd0 : head.word;
      frame_id    <= head.frame_id;
      status      <= is_status ? stat : xcfp_pkg::ST_OK;
      last        <= is_status;
    end
  end

  a_word_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_type == xcfp_pkg::REC_WORD) |-> (status == xcfp_pkg::ST_OK && !last))
    else $error("word record carries status bits");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_type == xcfp_pkg::REC_STATUS) |-> (last && data_word == 16'd0))
    else $error("status record malformed");

endmodule
